### rtl/rhmd_pkg.sv
// Shared types and constants for the readout hit/marker decoder.
`default_nettype none
package rhmd_pkg;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 136;
  localparam int unsigned ChipW    = 5;
  localparam int unsigned TimeW    = 42;
  localparam int unsigned HitTimeW = 44;
  localparam int unsigned BaseLsb  = 16;
  localparam int unsigned BaseW    = TimeW - BaseLsb;
  localparam int unsigned FrameLsb = 12;

  localparam logic [4:0] OfsNegOne = 5'h1f;

  // Decoded word, passed from front to back through the queue.
  typedef struct packed {
    logic                is_hit;
    logic [ChipW-1:0]    chip;
    logic signed [5:0]   frame_offset;
    logic [9:0]          adc;
    logic [11:0]         bunch_id;
    logic                over_flag;
    logic [5:0]          channel;
    logic [7:0]          tdc;
    logic [TimeW-1:0]    marker_time;
  } dec_t;

  function automatic logic [11:0] gray_to_bin(input logic [11:0] g);
    logic [11:0] b;
    b[11] = g[11];
    for (int i = 10; i >= 0; i--) begin
      b[i] = b[i+1] ^ g[i];
    end
    return b;
  endfunction

endpackage
`default_nettype wire

### rtl/rhmd_front.sv
// Front end: splits a readout word into marker or hit fields.
`default_nettype none
module rhmd_front (
  input  wire logic [rhmd_pkg::InDataW-1:0] word_i,
  output rhmd_pkg::dec_t                    dec_o
);
  import rhmd_pkg::*;

  logic [31:0] hi;
  logic [15:0] lo;
  logic [4:0]  raw_ofs;

  assign hi      = word_i[31:0];
  assign lo      = word_i[47:32];
  assign raw_ofs = hi[31:27];

  always_comb begin
    dec_o = '0;
    dec_o.is_hit = lo[15];
    if (lo[15]) begin
      dec_o.chip         = hi[26:22];
      dec_o.frame_offset = (raw_ofs == OfsNegOne) ? -6'sd1 : $signed({1'b0, raw_ofs});
      dec_o.adc          = hi[21:12];
      dec_o.bunch_id     = gray_to_bin(hi[11:0]);
      dec_o.over_flag    = lo[14];
      dec_o.channel      = lo[13:8];
      dec_o.tdc          = lo[7:0];
    end else begin
      dec_o.chip        = lo[14:10];
      dec_o.marker_time = {hi, lo[9:0]};
    end
  end

endmodule
`default_nettype wire

### rtl/rhmd_fifo.sv
// Short queue between the decode front and the timing back end.
`default_nettype none
module rhmd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire rhmd_pkg::dec_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output rhmd_pkg::dec_t      data_o,
  output logic                empty_o
);
  import rhmd_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  dec_t             mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

### rtl/rhmd_back.sv
// Back end: chip time base table, hit time add and output register.
`default_nettype none
module rhmd_back #(
  parameter int unsigned NumChips = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_empty_i,
  input  wire rhmd_pkg::dec_t                q_data_i,
  output logic                               q_pop_o,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [rhmd_pkg::OutDataW-1:0]      m_axis_tdata_o,
  output logic                               m_axis_tuser_o
);
  import rhmd_pkg::*;

  localparam int unsigned IdxW = (NumChips > 1) ? $clog2(NumChips) : 1;

  logic [BaseW-1:0]      base_q [NumChips];
  logic                  in_range;
  logic [IdxW-1:0]       idx;
  logic [BaseW-1:0]      base;
  logic [HitTimeW-1:0]   hit_time;
  logic                  vld_q, vld_d;
  logic [OutDataW-1:0]   data_q, data_d;
  logic                  user_q, user_d;

  assign in_range = ({27'd0, q_data_i.chip} < 32'(NumChips));
  assign idx      = IdxW'(q_data_i.chip);
  assign base     = in_range ? base_q[idx] : '0;
  assign q_pop_o  = !q_empty_i && (!vld_q || m_axis_tready_i);

  // base has its low 16 bits clear; offset is scaled by 4096
  assign hit_time = {2'b00, base, {BaseLsb{1'b0}}}
                  + {{(HitTimeW - 6 - FrameLsb){q_data_i.frame_offset[5]}},
                     q_data_i.frame_offset, {FrameLsb{1'b0}}}
                  + {{(HitTimeW - 12){1'b0}}, q_data_i.bunch_id};

  always_comb begin
    vld_d  = vld_q;
    data_d = data_q;
    user_d = user_q;
    if (m_axis_tready_i) begin
      vld_d = 1'b0;
    end
    if (q_pop_o) begin
      vld_d  = 1'b1;
      user_d = q_data_i.is_hit;
      data_d = {2'b00,
                q_data_i.marker_time,
                q_data_i.is_hit ? hit_time : {HitTimeW{1'b0}},
                q_data_i.tdc,
                q_data_i.channel,
                q_data_i.over_flag,
                q_data_i.bunch_id,
                q_data_i.adc,
                q_data_i.frame_offset,
                q_data_i.chip};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    user_q <= user_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChips; i++) begin
        base_q[i] <= '0;
      end
    end else if (q_pop_o && !q_data_i.is_hit && in_range) begin
      base_q[idx] <= q_data_i.marker_time[TimeW-1:BaseLsb];
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = user_q;

endmodule
`default_nettype wire

### rtl/readout_hit_marker_decoder.sv
// Top level of the readout hit/marker decoder.
`default_nettype none
// Decodes one 48-bit readout word per beat, at a sustained rate of one beat
// per clock while m_axis_tready_i is held high. A marker word (word_low bit
// 15 clear) loads its chip's time base (42-bit timestamp with the low 16
// bits cleared) and returns the full timestamp; a hit word returns its
// unpacked fields and hit time = base + offset*4096 + decoded BCID, 44-bit
// two's complement. The front decodes in the accept cycle into a short
// queue; the back end reads the per-chip base table, does the add and
// registers the result. Words flow strictly in order, so a hit always sees
// every earlier marker. All bases are zero after reset.
module readout_hit_marker_decoder #(
  parameter int unsigned NUM_CHIPS  = 32,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [31:0] word_high, [47:32] word_low
  input  wire logic [rhmd_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [4:0] chip_index, [10:5] frame_offset, [20:11] adc_value,
  // [32:21] bunch_id, [33] over_flag, [39:34] channel, [47:40] tdc_value,
  // [91:48] hit_time, [133:92] marker_time, [135:134] zero
  output logic [rhmd_pkg::OutDataW-1:0]      m_axis_tdata_o,
  // [0] is_hit
  output logic                               m_axis_tuser_o
);
  import rhmd_pkg::*;

  dec_t front_dec, q_data;
  logic q_full, q_empty, q_pop;

  assign s_axis_tready_o = !q_full;

  rhmd_front u_front (
    .word_i (s_axis_tdata_i),
    .dec_o  (front_dec)
  );

  rhmd_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid_i),
    .data_i  (front_dec),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .empty_o (q_empty)
  );

  rhmd_back #(
    .NumChips (NUM_CHIPS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_data_i        (q_data),
    .q_pop_o         (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule
`default_nettype wire
